// ----- rtl/core/bffa_pkg.sv -----
// ----------------------------------------------------------------------------
// bffa_pkg: shared types and constants for the bitmap first-fit allocator
// Request and status codes, sequencer states and the lowest-zero search.
// ----------------------------------------------------------------------------
package bffa_pkg;

   // Map word width scanned per cycle
   localparam int WORD_W = 32;
   localparam int POS_W  = 5;

   // Payload field widths
   localparam int REQ_TYPE_W   = 2;
   localparam int UNIT_INDEX_W = 12;
   localparam int STATUS_W     = 3;
   localparam int GRANT_W      = 11;
   localparam int COUNT_W      = 12;
   localparam int LIMIT_W      = 12;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_FLUSH = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FLUSHED   = 3'd4;

   // Reset value of the free counter limit
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2048;

   // Sequencer states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_CHK,
      S_DONE
   } state_type;

   // Position of the lowest clear bit (only meaningful if one exists)
   function automatic logic [POS_W-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            pos = POS_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// ----- rtl/core/bffa_req_if.sv -----
// ----------------------------------------------------------------------------
// bffa_req_if: request channel of the allocator
// Valid/ready handshake carrying the request type and the unit index.
// ----------------------------------------------------------------------------
interface bffa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [bffa_pkg::REQ_TYPE_W-1:0]      req_type;
   logic [bffa_pkg::UNIT_INDEX_W-1:0]    unit_index;

   modport source (output valid, output req_type, output unit_index, input ready);
   modport sink   (input valid, input req_type, input unit_index, output ready);
endinterface

// ----- rtl/core/bffa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bffa_rsp_if: result channel of the allocator
// Valid/ready handshake carrying status, granted index, counter and mark.
// ----------------------------------------------------------------------------
interface bffa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bffa_pkg::STATUS_W-1:0]    status;
   logic [bffa_pkg::GRANT_W-1:0]     granted_index;
   logic [bffa_pkg::COUNT_W-1:0]     free_count;
   logic                             changed;

   modport source (output valid, output status, output granted_index,
                   output free_count, output changed, input ready);
   modport sink   (input valid, input status, input granted_index,
                   input free_count, input changed, output ready);
endinterface

// ----- rtl/core/bffa_ram.sv -----
// ----------------------------------------------------------------------------
// bffa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bitmap_first_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator: usage bitmap allocator with first-fit search
// Allocate, free and flush requests against a bitmap of NUM_UNITS units.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink)  : req_type (0 allocate, 1 free, 2 flush) and unit_index.
//   rsp (source): status, granted_index, free_count, changed; one per request.
//   csr_we/csr_wdata write the free counter limit; the user must do so only while idle.
// The map lives in a RAM of WORDS = ceil(NUM_UNITS/32) words of 32 bits. One
// shared compare and lowest-zero encoder checks one word per cycle.
// Path from request transfer to result valid:
//   allocate: reads words in order from word 0 and stops at the word holding
//             the first free unit, or after the last word when nothing is free.
//   free: one read of the index's word, then a bit check (none out of range).
//   flush and unused codes: straight to the done state, then the output register.
// One request is in flight at a time; req.ready is high only when idle.
// Throughput is set by the word-per-cycle scan over the RAM read port, as long
// as rsp.ready drains the output register. Reset starts a clearing pass that
// zeroes all WORDS map words, req.ready low meanwhile. The csr port works always.
// The result sits in an output register; a new request is taken while it
// waits, but that request's result holds until rsp.ready drains the register.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator #(
   parameter int NUM_UNITS = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   bffa_req_if.sink                          req,
   bffa_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [bffa_pkg::LIMIT_W-1:0]      csr_wdata
);

   localparam int WW    = bffa_pkg::WORD_W;
   localparam int PW    = bffa_pkg::POS_W;
   localparam int WORDS = (NUM_UNITS + WW - 1) / WW;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int TAIL  = NUM_UNITS - WW * (WORDS - 1);
   localparam int CW    = $clog2(NUM_UNITS + 1);
   localparam int CMPW  = (CW > bffa_pkg::LIMIT_W) ? CW : bffa_pkg::LIMIT_W;
   localparam int IW    = WAW + PW;
   localparam int GW    = (IW > bffa_pkg::GRANT_W) ? IW : bffa_pkg::GRANT_W;
   localparam int UW    = 17;
   localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
   localparam logic [WW:0]    TAIL_ONES = (WW + 1)'((WW + 1)'(1) << TAIL) - (WW + 1)'(1);
   localparam logic [WW-1:0]  TAIL_MASK = TAIL_ONES[WW-1:0];

   // Registers
   bffa_pkg::state_type               state_ff, state_in;
   logic [WAW-1:0]                    addr_ff, addr_in;
   logic                              issue_vld_ff, issue_vld_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [WAW-1:0]                    chk_addr_ff, chk_addr_in;
   logic [PW-1:0]                     bit_ff, bit_in;
   logic [CW-1:0]                     cnt_ff, cnt_in;
   logic                              mark_ff, mark_in;
   logic [bffa_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic [bffa_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [IW-1:0]                     grant_ff, grant_in;
   logic                              rsp_vld_ff, rsp_vld_in;
   logic [bffa_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [bffa_pkg::GRANT_W-1:0]      rsp_grant_ff, rsp_grant_in;
   logic [bffa_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                              rsp_changed_ff, rsp_changed_in;

   // RAM ports
   logic            wr_en, rd_en;
   logic [WAW-1:0]  wr_addr, rd_addr;
   logic [WW-1:0]   wr_data, rd_data;

   // Helpers
   logic [WAW+11:0]  uidx_ext;
   logic [WAW-1:0]   uidx_word;
   logic             uidx_ok;
   logic             req_xfer, slot_free;
   logic [WW-1:0]    scan_word;
   logic             scan_found;
   logic [PW-1:0]    scan_pos;
   logic             cnt_below;
   logic [CMPW-1:0]  cnt_wide;
   logic [GW-1:0]    grant_wide;

   bffa_ram #(
      .WIDTH(WW),
      .DEPTH(WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request decode
   assign req.ready = (state_ff == bffa_pkg::S_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign uidx_ext  = (WAW + 12)'(req.unit_index);
   assign uidx_word = uidx_ext[WAW+4:5];
   assign uidx_ok   = UW'(req.unit_index) < UW'(NUM_UNITS);

   // Shared scan unit: tail bits past NUM_UNITS count as used
   assign scan_word  = rd_data | ((chk_addr_ff == LAST_WORD) ? ~TAIL_MASK : '0);
   assign scan_found = (scan_word != '1);
   assign scan_pos   = bffa_pkg::first_zero(scan_word);

   assign cnt_below  = CMPW'(cnt_ff) < CMPW'(limit_ff);
   assign cnt_wide   = CMPW'(cnt_in);
   assign grant_wide = GW'(grant_ff);
   assign slot_free  = !rsp_vld_ff || rsp.ready;

   // Sequencer: next state, RAM control, counter and result
   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      issue_vld_in   = issue_vld_ff;
      chk_vld_in     = 1'b0;
      chk_addr_in    = chk_addr_ff;
      bit_in         = bit_ff;
      cnt_in         = cnt_ff;
      mark_in        = mark_ff;
      limit_in       = csr_we ? csr_wdata : limit_ff;
      status_in      = status_ff;
      grant_in       = grant_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_grant_in   = rsp_grant_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_changed_in = rsp_changed_ff;
      wr_en          = 1'b0;
      wr_addr        = chk_addr_ff;
      wr_data        = '0;
      rd_en          = 1'b0;
      rd_addr        = addr_ff;

      case (state_ff)
         bffa_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            addr_in = addr_ff + WAW'(1);
            if (addr_ff == LAST_WORD) begin
               addr_in  = '0;
               state_in = bffa_pkg::S_IDLE;
            end
         end

         bffa_pkg::S_IDLE: begin
            if (req_xfer) begin
               grant_in = '0;
               case (req.req_type)
                  bffa_pkg::REQ_ALLOC: begin
                     addr_in      = '0;
                     issue_vld_in = 1'b1;
                     state_in     = bffa_pkg::S_SCAN;
                  end
                  bffa_pkg::REQ_FREE: begin
                     if (uidx_ok) begin
                        rd_en       = 1'b1;
                        rd_addr     = uidx_word;
                        chk_addr_in = uidx_word;
                        bit_in      = req.unit_index[PW-1:0];
                        state_in    = bffa_pkg::S_FREE_CHK;
                     end else begin
                        status_in = bffa_pkg::ST_IGNORED;
                        state_in  = bffa_pkg::S_DONE;
                     end
                  end
                  bffa_pkg::REQ_FLUSH: begin
                     mark_in   = 1'b0;
                     status_in = bffa_pkg::ST_FLUSHED;
                     state_in  = bffa_pkg::S_DONE;
                  end
                  default: begin
                     status_in = bffa_pkg::ST_IGNORED;
                     state_in  = bffa_pkg::S_DONE;
                  end
               endcase
            end
         end

         bffa_pkg::S_SCAN: begin
            // issue side: one word read per cycle
            if (issue_vld_ff) begin
               rd_en       = 1'b1;
               rd_addr     = addr_ff;
               chk_vld_in  = 1'b1;
               chk_addr_in = addr_ff;
               addr_in     = addr_ff + WAW'(1);
               if (addr_ff == LAST_WORD) begin
                  issue_vld_in = 1'b0;
               end
            end
            // check side: word read in the previous cycle
            if (chk_vld_ff) begin
               if (scan_found) begin
                  wr_en        = 1'b1;
                  wr_addr      = chk_addr_ff;
                  wr_data      = rd_data | (WW'(1) << scan_pos);
                  if (cnt_ff != '0) begin
                     cnt_in = cnt_ff - CW'(1);
                  end
                  mark_in      = 1'b1;
                  status_in    = bffa_pkg::ST_ALLOCATED;
                  grant_in     = {chk_addr_ff, scan_pos};
                  issue_vld_in = 1'b0;
                  chk_vld_in   = 1'b0;
                  state_in     = bffa_pkg::S_DONE;
               end else if (chk_addr_ff == LAST_WORD) begin
                  status_in    = bffa_pkg::ST_NONE_FREE;
                  issue_vld_in = 1'b0;
                  chk_vld_in   = 1'b0;
                  state_in     = bffa_pkg::S_DONE;
               end
            end
         end

         bffa_pkg::S_FREE_CHK: begin
            if (rd_data[bit_ff]) begin
               wr_en   = 1'b1;
               wr_addr = chk_addr_ff;
               wr_data = rd_data & ~(WW'(1) << bit_ff);
               if (cnt_below) begin
                  cnt_in = cnt_ff + CW'(1);
               end
               mark_in   = 1'b1;
               status_in = bffa_pkg::ST_FREED;
            end else begin
               status_in = bffa_pkg::ST_IGNORED;
            end
            state_in = bffa_pkg::S_DONE;
         end

         bffa_pkg::S_DONE: begin
            // hand the result to the output register once it is free
            if (slot_free) begin
               rsp_vld_in     = 1'b1;
               rsp_status_in  = status_ff;
               rsp_grant_in   = grant_wide[bffa_pkg::GRANT_W-1:0];
               rsp_count_in   = cnt_wide[bffa_pkg::COUNT_W-1:0];
               rsp_changed_in = mark_ff;
               state_in       = bffa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bffa_pkg::S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bffa_pkg::S_CLEAR;
         addr_ff      <= '0;
         issue_vld_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         cnt_ff       <= CW'(NUM_UNITS);
         mark_ff      <= 1'b0;
         limit_ff     <= bffa_pkg::LIMIT_RESET;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         issue_vld_ff <= issue_vld_in;
         chk_vld_ff   <= chk_vld_in;
         cnt_ff       <= cnt_in;
         mark_ff      <= mark_in;
         limit_ff     <= limit_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_addr_ff    <= chk_addr_in;
      bit_ff         <= bit_in;
      status_ff      <= status_in;
      grant_ff       <= grant_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_grant_ff   <= rsp_grant_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   // Result channel
   assign rsp.valid         = rsp_vld_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.granted_index = rsp_grant_ff;
   assign rsp.free_count    = rsp_count_ff;
   assign rsp.changed       = rsp_changed_ff;

endmodule

// ----- rtl/core/bffa_checker.sv -----
// ----------------------------------------------------------------------------
// bffa_checker: port-level assertions for the allocator
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bffa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bffa_pkg::STATUS_W-1:0]   rsp_status,
   input logic [bffa_pkg::GRANT_W-1:0]    rsp_granted_index,
   input logic [bffa_pkg::COUNT_W-1:0]    rsp_free_count,
   input logic                            rsp_changed
);

   // Clearing pass blocks requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_index) && $stable(rsp_free_count)
         && $stable(rsp_changed))
      else $error("stalled result changed");

   // Granted index is zero unless a unit was allocated
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bffa_pkg::ST_ALLOCATED |-> rsp_granted_index == '0)
      else $error("granted index set on non-allocate result");

   // A map change sets the change mark
   a_mark_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bffa_pkg::ST_ALLOCATED
         || rsp_status == bffa_pkg::ST_FREED) |-> rsp_changed)
      else $error("change mark clear after map change");

   // Flush leaves the change mark clear
   a_flush_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bffa_pkg::ST_FLUSHED |-> !rsp_changed)
      else $error("change mark set after flush");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_granted_index (rsp.granted_index),
   .rsp_free_count    (rsp.free_count),
   .rsp_changed       (rsp.changed)
);
